[sv/can_rrt_pkg.sv]
// ----------------------------------------------------------------------------
// CAN request/response tracker package
// Op and event codes, request status codes, memory row layouts.
// ----------------------------------------------------------------------------
package can_rrt_pkg;

    localparam int RESPONSE_ENTRIES_DEF = 16;
    localparam int REQUEST_ENTRIES_DEF  = 16;

    localparam logic [2:0] OP_RX        = 3'd0;
    localparam logic [2:0] OP_CYCLE     = 3'd1;
    localparam logic [2:0] OP_SEND      = 3'd2;
    localparam logic [2:0] OP_LOAD_RESP = 3'd3;
    localparam logic [2:0] OP_LOAD_REQ  = 3'd4;

    localparam logic [2:0] EV_MATCH   = 3'd0;
    localparam logic [2:0] EV_UNRECOG = 3'd1;
    localparam logic [2:0] EV_RESP_TO = 3'd2;
    localparam logic [2:0] EV_TX      = 3'd3;
    localparam logic [2:0] EV_REQ_TO  = 3'd4;
    localparam logic [2:0] EV_DONE    = 3'd5;
    localparam logic [2:0] EV_ACK     = 3'd6;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEND     = 3'd1;
    localparam logic [2:0] ST_WAITING  = 3'd2;
    localparam logic [2:0] ST_COMPLETE = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    localparam logic [4:0] LINK_LIMIT = 5'd16;

    typedef struct packed {
        logic [28:0] id;
        logic [7:0]  flags;
        logic [3:0]  len;
        logic [63:0] data;
        logic        check;
        logic [31:0] limit;
        logic [4:0]  link;
        logic [31:0] last_seen;
        logic [31:0] rx_total;
    } resp_row_t;

    typedef struct packed {
        logic [28:0] id;
        logic [7:0]  flags;
        logic [3:0]  len;
        logic [63:0] data;
        logic [31:0] limit;
        logic [31:0] sent_at;
        logic [31:0] tx_total;
        logic [31:0] to_total;
    } req_row_t;

endpackage

[sv/can_rrt_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module can_rrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/can_request_response_tracker.sv]
// Frame items scan the templates one entry at a time up to the match. Cycle items
// walk each response entry, then each request entry twice (timeouts, then sends),
// one entry at a time with a read/modify/write over the two table RAMs.
// One item at a time; output stalls hold the walk.
// Reset clears valid, status and count-valid flags at once; the RAMs are not
// cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
// CAN request/response tracker
// Template matching, timeout checks and request transmission over two RAMs.
// ----------------------------------------------------------------------------
module can_request_response_tracker #(
    parameter int RESPONSE_ENTRIES = can_rrt_pkg::RESPONSE_ENTRIES_DEF,
    parameter int REQUEST_ENTRIES  = can_rrt_pkg::REQUEST_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [31:0] now_time,
    input  logic [28:0] frame_id,
    input  logic [7:0]  frame_flags,
    input  logic [3:0]  frame_len,
    input  logic [63:0] frame_data,
    input  logic [3:0]  entry_index,
    input  logic [4:0]  linked_request,
    input  logic [31:0] timeout_limit,
    input  logic        timeout_enable,
    input  logic        await_reply,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_res,
    output logic [3:0]  entry_number,
    output logic [28:0] out_id,
    output logic [7:0]  out_flags,
    output logic [3:0]  out_len,
    output logic [63:0] out_data,
    output logic [31:0] event_count,
    output logic        flush_needed,
    output logic        last
);

    localparam int RAW = RESPONSE_ENTRIES > 1 ? $clog2(RESPONSE_ENTRIES) : 1;
    localparam int QAW = REQUEST_ENTRIES > 1 ? $clog2(REQUEST_ENTRIES) : 1;
    localparam int CW  = RAW > QAW ? RAW : QAW;
    localparam int RW  = $bits(can_rrt_pkg::resp_row_t);
    localparam int QW  = $bits(can_rrt_pkg::req_row_t);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [2:0] PH_MATCH = 3'd0;
    localparam logic [2:0] PH_RTO   = 3'd1;
    localparam logic [2:0] PH_QTO   = 3'd2;
    localparam logic [2:0] PH_TX    = 3'd3;
    localparam logic [2:0] PH_LOAD  = 3'd4;

    localparam logic [CW-1:0] R_LAST = CW'(RESPONSE_ENTRIES - 1);
    localparam logic [CW-1:0] Q_LAST = CW'(REQUEST_ENTRIES - 1);

    logic [1:0]    state_reg, state_next;
    logic [2:0]    phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          flush_reg, flush_next;

    logic [RESPONSE_ENTRIES-1:0] valid_reg, valid_next;
    logic [RESPONSE_ENTRIES-1:0] rx_ok_reg, rx_ok_next;
    logic [REQUEST_ENTRIES-1:0]  cnt_ok_reg, cnt_ok_next;
    logic [REQUEST_ENTRIES-1:0]  wants_reg, wants_next;
    logic [REQUEST_ENTRIES-1:0]  qchk_reg, qchk_next;
    logic [2:0] status_reg [REQUEST_ENTRIES];
    logic [2:0] status_next [REQUEST_ENTRIES];

    // captured input item
    logic [2:0]  op_reg;
    logic [31:0] now_reg;
    logic [28:0] id_reg;
    logic [7:0]  flags_reg;
    logic [3:0]  len_reg;
    logic [63:0] data_reg;
    logic [4:0]  link_reg;
    logic [31:0] limit_reg;
    logic        chk_reg;
    logic        wants_in_reg;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  ev_reg;
    logic [3:0]  entry_reg;
    logic [28:0] oid_reg;
    logic [7:0]  oflags_reg;
    logic [3:0]  olen_reg;
    logic [63:0] odata_reg;
    logic [31:0] ocount_reg;
    logic        oflush_reg;
    logic        olast_reg;

    logic        emit;
    logic [2:0]  e_ev;
    logic [28:0] e_id;
    logic [7:0]  e_flags;
    logic [3:0]  e_len;
    logic [63:0] e_data;
    logic [31:0] e_count;
    logic        e_flush;
    logic        e_last;

    logic        in_xfer, slot_free, rd_en, resp_we, req_we;
    logic [RW-1:0] resp_rdata;
    logic [QW-1:0] req_rdata;
    can_rrt_pkg::resp_row_t rrow, rwrow;
    can_rrt_pkg::req_row_t  qrow, qwrow;
    logic [RAW-1:0] ri;
    logic [QAW-1:0] qi;
    logic [31:0] rx_cur, tx_cur, to_cur;
    logic [3:0]  tlen;
    logic [63:0] dmask;
    logic        tmatch;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign ri = cnt_reg[RAW-1:0];
    assign qi = cnt_reg[QAW-1:0];
    assign rrow = can_rrt_pkg::resp_row_t'(resp_rdata);
    assign qrow = can_rrt_pkg::req_row_t'(req_rdata);
    assign rx_cur = rx_ok_reg[ri] ? rrow.rx_total : 32'd0;
    assign tx_cur = cnt_ok_reg[qi] ? qrow.tx_total : 32'd0;
    assign to_cur = cnt_ok_reg[qi] ? qrow.to_total : 32'd0;

    can_rrt_ram #(.WIDTH(RW), .DEPTH(RESPONSE_ENTRIES)) u_resp_ram (
        .clk   (clk),
        .we    (resp_we),
        .waddr (ri),
        .wdata (RW'(rwrow)),
        .re    (rd_en),
        .raddr (ri),
        .rdata (resp_rdata)
    );

    can_rrt_ram #(.WIDTH(QW), .DEPTH(REQUEST_ENTRIES)) u_req_ram (
        .clk   (clk),
        .we    (req_we),
        .waddr (qi),
        .wdata (QW'(qwrow)),
        .re    (rd_en),
        .raddr (qi),
        .rdata (req_rdata)
    );

    // compared data bytes: template length clamped to 8
    always_comb
    begin
        tlen = (rrow.len > 4'd8) ? 4'd8 : rrow.len;
        for (int b = 0; b < 8; b++)
        begin
            dmask[8*b +: 8] = (4'(b) < tlen) ? 8'hFF : 8'h00;
        end
        tmatch = (rrow.flags == flags_reg) && (rrow.id == id_reg)
                 && (((rrow.data ^ data_reg) & dmask) == 64'd0);
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        flush_next  = flush_reg;
        valid_next  = valid_reg;
        rx_ok_next  = rx_ok_reg;
        cnt_ok_next = cnt_ok_reg;
        wants_next  = wants_reg;
        qchk_next   = qchk_reg;
        status_next = status_reg;
        rd_en   = 1'b0;
        resp_we = 1'b0;
        req_we  = 1'b0;
        rwrow   = rrow;
        rwrow.rx_total = rx_cur;
        qwrow   = qrow;
        qwrow.tx_total = tx_cur;
        qwrow.to_total = to_cur;
        emit    = 1'b0;
        e_ev    = can_rrt_pkg::EV_ACK;
        e_id    = '0;
        e_flags = '0;
        e_len   = '0;
        e_data  = '0;
        e_count = '0;
        e_flush = 1'b0;
        e_last  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cnt_next   = '0;
                    flush_next = 1'b0;
                    state_next = S_FIN;
                    unique case (op)
                        can_rrt_pkg::OP_RX:
                        begin
                            phase_next = PH_MATCH;
                            state_next = S_READ;
                        end
                        can_rrt_pkg::OP_CYCLE:
                        begin
                            phase_next = PH_RTO;
                            state_next = S_READ;
                        end
                        can_rrt_pkg::OP_SEND:
                        begin
                            for (int j = 0; j < REQUEST_ENTRIES; j++)
                            begin
                                if (32'(entry_index) == j)
                                begin
                                    status_next[j] = can_rrt_pkg::ST_SEND;
                                end
                            end
                        end
                        can_rrt_pkg::OP_LOAD_RESP:
                        begin
                            if (32'(entry_index) < RESPONSE_ENTRIES)
                            begin
                                cnt_next   = CW'(entry_index);
                                phase_next = PH_LOAD;
                                state_next = S_READ;
                            end
                        end
                        can_rrt_pkg::OP_LOAD_REQ:
                        begin
                            if (32'(entry_index) < REQUEST_ENTRIES)
                            begin
                                cnt_next   = CW'(entry_index);
                                phase_next = PH_LOAD;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                unique case (phase_reg)
                    PH_MATCH:
                    begin
                        if (valid_reg[ri] && tmatch)
                        begin
                            if (slot_free)
                            begin
                                resp_we = 1'b1;
                                rwrow.last_seen = now_reg;
                                rwrow.rx_total  = rx_cur + 32'd1;
                                rx_ok_next[ri]  = 1'b1;
                                for (int j = 0; j < REQUEST_ENTRIES; j++)
                                begin
                                    if (rrow.link < can_rrt_pkg::LINK_LIMIT
                                        && 32'(rrow.link) == j)
                                    begin
                                        status_next[j] = can_rrt_pkg::ST_COMPLETE;
                                    end
                                end
                                emit    = 1'b1;
                                e_ev    = can_rrt_pkg::EV_MATCH;
                                e_count = rx_cur + 32'd1;
                                e_last  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else if (cnt_reg == R_LAST)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    PH_RTO:
                    begin
                        if (!(valid_reg[ri] && rrow.check
                              && (now_reg - rrow.last_seen) > rrow.limit) || slot_free)
                        begin
                            if (valid_reg[ri] && rrow.check
                                && (now_reg - rrow.last_seen) > rrow.limit)
                            begin
                                emit = 1'b1;
                                e_ev = can_rrt_pkg::EV_RESP_TO;
                            end
                            state_next = S_READ;
                            if (cnt_reg == R_LAST)
                            begin
                                cnt_next   = '0;
                                phase_next = PH_QTO;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    end
                    PH_QTO:
                    begin
                        if (!(status_reg[qi] == can_rrt_pkg::ST_WAITING && qchk_reg[qi]
                              && (now_reg - qrow.sent_at) > qrow.limit) || slot_free)
                        begin
                            if (status_reg[qi] == can_rrt_pkg::ST_WAITING && qchk_reg[qi]
                                && (now_reg - qrow.sent_at) > qrow.limit)
                            begin
                                req_we = 1'b1;
                                qwrow.to_total  = to_cur + 32'd1;
                                cnt_ok_next[qi] = 1'b1;
                                status_next[qi] = can_rrt_pkg::ST_TIMEOUT;
                                emit    = 1'b1;
                                e_ev    = can_rrt_pkg::EV_REQ_TO;
                                e_count = to_cur + 32'd1;
                            end
                            state_next = S_READ;
                            if (cnt_reg == Q_LAST)
                            begin
                                cnt_next   = '0;
                                phase_next = PH_TX;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    end
                    PH_TX:
                    begin
                        if (status_reg[qi] != can_rrt_pkg::ST_SEND || slot_free)
                        begin
                            if (status_reg[qi] == can_rrt_pkg::ST_SEND)
                            begin
                                req_we = 1'b1;
                                qwrow.sent_at   = now_reg;
                                qwrow.tx_total  = tx_cur + 32'd1;
                                cnt_ok_next[qi] = 1'b1;
                                status_next[qi] = wants_reg[qi] ? can_rrt_pkg::ST_WAITING
                                                                : can_rrt_pkg::ST_COMPLETE;
                                flush_next = 1'b1;
                                emit    = 1'b1;
                                e_ev    = can_rrt_pkg::EV_TX;
                                e_id    = qrow.id;
                                e_flags = qrow.flags;
                                e_len   = qrow.len;
                                e_data  = qrow.data;
                                e_count = tx_cur + 32'd1;
                            end
                            if (cnt_reg == Q_LAST)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                        // table load; counts read back so they are kept
                        if (op_reg == can_rrt_pkg::OP_LOAD_RESP)
                        begin
                            resp_we = 1'b1;
                            rwrow.id        = id_reg;
                            rwrow.flags     = flags_reg;
                            rwrow.len       = len_reg;
                            rwrow.data      = data_reg;
                            rwrow.check     = chk_reg;
                            rwrow.limit     = limit_reg;
                            rwrow.link      = link_reg;
                            rwrow.last_seen = now_reg;
                            rx_ok_next[ri]  = 1'b1;
                            valid_next[ri]  = 1'b1;
                        end
                        else
                        begin
                            req_we = 1'b1;
                            qwrow.id    = id_reg;
                            qwrow.flags = flags_reg;
                            qwrow.len   = len_reg;
                            qwrow.data  = data_reg;
                            qwrow.limit = limit_reg;
                            cnt_ok_next[qi] = 1'b1;
                            status_next[qi] = can_rrt_pkg::ST_IDLE;
                            wants_next[qi]  = wants_in_reg;
                            qchk_next[qi]   = chk_reg;
                        end
                        state_next = S_FIN;
                    end
                endcase
            end
            default:
            begin
                if (slot_free)
                begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    unique case (op_reg)
                        can_rrt_pkg::OP_RX:    e_ev = can_rrt_pkg::EV_UNRECOG;
                        can_rrt_pkg::OP_CYCLE:
                        begin
                            e_ev    = can_rrt_pkg::EV_DONE;
                            e_flush = flush_reg;
                        end
                        default:               e_ev = can_rrt_pkg::EV_ACK;
                    endcase
                    state_next = S_IDLE;
                end
            end
        endcase

        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_MATCH;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            valid_reg     <= '0;
            rx_ok_reg     <= '0;
            cnt_ok_reg    <= '0;
            wants_reg     <= '0;
            qchk_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < REQUEST_ENTRIES; j++)
            begin
                status_reg[j] <= can_rrt_pkg::ST_IDLE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            valid_reg     <= valid_next;
            rx_ok_reg     <= rx_ok_next;
            cnt_ok_reg    <= cnt_ok_next;
            wants_reg     <= wants_next;
            qchk_reg      <= qchk_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg       <= op;
            now_reg      <= now_time;
            id_reg       <= frame_id;
            flags_reg    <= frame_flags;
            len_reg      <= frame_len;
            data_reg     <= frame_data;
            link_reg     <= linked_request;
            limit_reg    <= timeout_limit;
            chk_reg      <= timeout_enable;
            wants_in_reg <= await_reply;
        end
        if (emit)
        begin
            ev_reg     <= e_ev;
            entry_reg  <= (e_ev == can_rrt_pkg::EV_UNRECOG || e_ev == can_rrt_pkg::EV_DONE
                           || e_ev == can_rrt_pkg::EV_ACK) ? 4'd0 : 4'(cnt_reg);
            oid_reg    <= e_id;
            oflags_reg <= e_flags;
            olen_reg   <= e_len;
            odata_reg  <= e_data;
            ocount_reg <= e_count;
            oflush_reg <= e_flush;
            olast_reg  <= e_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = ev_reg;
    assign entry_number = entry_reg;
    assign out_id       = oid_reg;
    assign out_flags    = oflags_reg;
    assign out_len      = olen_reg;
    assign out_data     = odata_reg;
    assign event_count  = ocount_reg;
    assign flush_needed = oflush_reg;
    assign last         = olast_reg;

endmodule
